### sv/ntf_pkg.sv
// Shared types, constants and the thermistor ROM for the trimmed-mean ADC filter.
package ntf_pkg;

  localparam int unsigned TableLen  = 250;
  localparam int unsigned BlockLen  = 10;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 6;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    RegDirectMode    = 2'd0,
    RegInvertAverage = 2'd1,
    RegSettleTicks   = 2'd2,
    RegStableLimit   = 2'd3
  } cfg_reg_e;

  localparam logic [3:0] SettleTicksRst = 4'd10;
  localparam logic [5:0] StableLimitRst = 6'd50;
  localparam logic [7:0] HeldReadingRst = 8'd100;
  localparam logic [7:0] BlockMinRst    = 8'hff;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StOut
  } state_e;

  typedef struct packed {
    logic [7:0] sample;
    logic       channel_busy;
  } in_item_t;

  typedef struct packed {
    logic       reading_updated;
    logic [7:0] reading_code;
    logic [7:0] celsius;
    logic       reading_valid;
  } out_item_t;

  typedef struct packed {
    logic       direct_mode;
    logic       invert_average;
    logic [3:0] settle_ticks;
    logic [5:0] stable_limit;
  } cfg_t;

  // Filter status after one tick
  typedef struct packed {
    logic       updated;
    logic       need_lookup;
    logic [7:0] held_reading;
    logic       valid;
  } flt_stat_t;

  typedef struct packed {
    logic       start;
    logic [7:0] code;
  } lkp_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] celsius;
  } lkp_rsp_t;

  // Monotone thermistor curve; the last five entries read as 255
  localparam logic [7:0] NtcRom [256] = '{
    8'd3,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd5,   8'd6,
    8'd6,   8'd6,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,
    8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,  8'd14,  8'd14,
    8'd15,  8'd15,  8'd16,  8'd17,  8'd17,  8'd18,  8'd19,  8'd20,  8'd20,  8'd21,
    8'd22,  8'd23,  8'd24,  8'd24,  8'd25,  8'd26,  8'd27,  8'd28,  8'd29,  8'd30,
    8'd31,  8'd32,  8'd34,  8'd35,  8'd36,  8'd37,  8'd38,  8'd39,  8'd41,  8'd42,
    8'd43,  8'd45,  8'd46,  8'd47,  8'd49,  8'd50,  8'd52,  8'd53,  8'd55,  8'd56,
    8'd58,  8'd59,  8'd61,  8'd63,  8'd64,  8'd66,  8'd68,  8'd69,  8'd71,  8'd73,
    8'd74,  8'd76,  8'd78,  8'd80,  8'd82,  8'd83,  8'd85,  8'd87,  8'd89,  8'd91,
    8'd93,  8'd94,  8'd96,  8'd98,  8'd100, 8'd102, 8'd104, 8'd106, 8'd108, 8'd110,
    8'd112, 8'd113, 8'd115, 8'd117, 8'd119, 8'd121, 8'd123, 8'd125, 8'd127, 8'd129,
    8'd130, 8'd132, 8'd134, 8'd136, 8'd138, 8'd139, 8'd141, 8'd143, 8'd145, 8'd147,
    8'd148, 8'd150, 8'd152, 8'd153, 8'd155, 8'd157, 8'd158, 8'd160, 8'd162, 8'd163,
    8'd165, 8'd166, 8'd168, 8'd169, 8'd171, 8'd172, 8'd174, 8'd175, 8'd177, 8'd178,
    8'd179, 8'd181, 8'd182, 8'd183, 8'd185, 8'd186, 8'd187, 8'd188, 8'd190, 8'd191,
    8'd192, 8'd193, 8'd194, 8'd196, 8'd197, 8'd198, 8'd199, 8'd200, 8'd201, 8'd202,
    8'd203, 8'd204, 8'd205, 8'd206, 8'd207, 8'd208, 8'd209, 8'd209, 8'd210, 8'd211,
    8'd212, 8'd213, 8'd214, 8'd214, 8'd215, 8'd216, 8'd217, 8'd217, 8'd218, 8'd219,
    8'd219, 8'd220, 8'd221, 8'd221, 8'd222, 8'd223, 8'd223, 8'd224, 8'd224, 8'd225,
    8'd226, 8'd226, 8'd227, 8'd227, 8'd228, 8'd228, 8'd229, 8'd229, 8'd230, 8'd230,
    8'd231, 8'd231, 8'd232, 8'd232, 8'd232, 8'd233, 8'd233, 8'd234, 8'd234, 8'd234,
    8'd235, 8'd235, 8'd236, 8'd236, 8'd236, 8'd237, 8'd237, 8'd237, 8'd238, 8'd238,
    8'd238, 8'd239, 8'd239, 8'd239, 8'd239, 8'd240, 8'd240, 8'd240, 8'd240, 8'd241,
    8'd241, 8'd241, 8'd241, 8'd242, 8'd242, 8'd242, 8'd242, 8'd243, 8'd243, 8'd243,
    8'd243, 8'd243, 8'd244, 8'd244, 8'd244, 8'd244, 8'd244, 8'd245, 8'd245, 8'd245,
    8'd245, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

endpackage

### sv/ntc_adc_trimmed_mean_filter_unit.sv
// Top level: trimmed-mean ADC filter with thermistor lookup, handshake and config port.
//
//   channel | signals                             | direction | payload
//   in      | in_valid_i / in_ready_o             | input     | in_data_i (sample, busy)
//   out     | out_valid_o / out_ready_i           | output    | out_data_o (one per tick)
//   cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i    | input     | register writes, no stall
//
// A tick without a table lookup passes the walk and output states before its result is registered.
// A tick that replaces the reading in lookup mode also waits in the walk state for the
// table walk, which compares one ROM entry per cycle.
// in_ready_o is high only while no tick is in work; a waiting result holds the block.
// Reset is asynchronous, active low; no clearing pass is needed.
module ntc_adc_trimmed_mean_filter_unit #(
  parameter int unsigned TABLE_LEN = ntf_pkg::TableLen
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ntf_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ntf_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [ntf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ntf_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import ntf_pkg::*;

  state_e    state_q, state_d;
  cfg_t      cfg_q;
  flt_stat_t stat;
  lkp_req_t  lkp_req;
  lkp_rsp_t  lkp_rsp;
  logic      in_xfer;
  logic      out_free;
  logic      out_load;
  logic      out_valid_q;
  out_item_t out_q;
  logic [7:0] celsius_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.direct_mode    <= 1'b0;
      cfg_q.invert_average <= 1'b0;
      cfg_q.settle_ticks   <= SettleTicksRst;
      cfg_q.stable_limit   <= StableLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegDirectMode:    cfg_q.direct_mode    <= cfg_wdata_i[0];
        RegInvertAverage: cfg_q.invert_average <= cfg_wdata_i[0];
        RegSettleTicks:   cfg_q.settle_ticks   <= cfg_wdata_i[3:0];
        RegStableLimit:   cfg_q.stable_limit   <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  ntf_filter u_filter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_xfer),
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .stat_o (stat)
  );

  ntf_lookup #(
    .TABLE_LEN (TABLE_LEN)
  ) u_lookup (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lkp_req),
    .rsp_o  (lkp_rsp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_xfer) state_d = StWalk;
      end
      StWalk: begin
        if (lkp_rsp.done || (!lkp_req.start && !stat.need_lookup)) state_d = StOut;
      end
      StOut: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs of the sequencer; the first walk cycle starts the lookup if needed
  logic walk_first_q;
  always_comb begin
    in_ready_o    = 1'b0;
    lkp_req.start = 1'b0;
    lkp_req.code  = stat.held_reading;
    out_load      = 1'b0;
    case (state_q)
      StIdle: in_ready_o = 1'b1;
      StWalk: lkp_req.start = walk_first_q && stat.need_lookup;
      StOut:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      walk_first_q <= 1'b0;
      celsius_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      walk_first_q <= in_xfer;
      if (lkp_rsp.done) begin
        celsius_q <= lkp_rsp.celsius;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result for transfer
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.reading_updated <= stat.updated;
      out_q.reading_code    <= stat.held_reading;
      out_q.celsius         <= celsius_q;
      out_q.reading_valid   <= stat.valid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_done_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lkp_rsp.done |-> (state_q == StWalk))
    else $error("lookup done outside walk");
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("loaded result not shown");
  a_upd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.reading_updated) |-> out_data_o.reading_valid)
    else $error("updated reading without valid flag");
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("second tick taken while one is in work");
`endif

endmodule

### sv/ntf_filter.sv
// Settle counter, block min/max/sum accumulator, trimmed average and stability counter.
module ntf_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  ntf_pkg::in_item_t  item_i,
  input  ntf_pkg::cfg_t      cfg_i,
  output ntf_pkg::flt_stat_t stat_o
);
  import ntf_pkg::*;

  logic [3:0]  settle_q, settle_d;
  logic [11:0] sum_q, sum_d;
  logic [3:0]  count_q, count_d;
  logic [7:0]  max_q, max_d;
  logic [7:0]  min_q, min_d;
  logic [7:0]  avg_q, avg_d;
  logic [7:0]  held_q, held_d;
  logic [5:0]  stable_q, stable_d;
  logic        valid_q, valid_d;
  logic        upd_q, upd_d;
  logic        lkp_q, lkp_d;

  logic [3:0]  settle_inc;
  logic [11:0] sum_n;
  logic [3:0]  count_n;
  logic [7:0]  max_n, min_n;
  logic [11:0] trim;
  logic [7:0]  avg_blk;
  logic [5:0]  stable_inc;

  // Next state of one tick
  always_comb begin
    settle_d = settle_q;
    sum_d    = sum_q;
    count_d  = count_q;
    max_d    = max_q;
    min_d    = min_q;
    avg_d    = avg_q;
    held_d   = held_q;
    stable_d = stable_q;
    valid_d  = valid_q;
    upd_d    = 1'b0;
    lkp_d    = 1'b0;

    settle_inc = (settle_q < cfg_i.settle_ticks) ? settle_q + 4'd1 : settle_q;
    sum_n      = sum_q + {4'd0, item_i.sample};
    count_n    = count_q + 4'd1;
    max_n      = (item_i.sample >= max_q) ? item_i.sample : max_q;
    min_n      = (item_i.sample <= min_q) ? item_i.sample : min_q;
    trim       = sum_n - {4'd0, min_n} - {4'd0, max_n};
    avg_blk    = cfg_i.invert_average ? ~trim[10:3] : trim[10:3];
    stable_inc = stable_q + 6'd1;

    if (item_i.channel_busy) begin
      settle_d = '0;
      stable_d = '0;
    end else begin
      settle_d = settle_inc;
      if (settle_inc >= cfg_i.settle_ticks) begin
        sum_d   = sum_n;
        count_d = count_n;
        max_d   = max_n;
        min_d   = min_n;
        // Close the block: drop min and max, average the rest
        if (count_n >= 4'(BlockLen)) begin
          sum_d   = '0;
          count_d = '0;
          max_d   = '0;
          min_d   = BlockMinRst;
          avg_d   = avg_blk;
          if (cfg_i.direct_mode) begin
            held_d  = avg_blk;
            valid_d = 1'b1;
            upd_d   = 1'b1;
          end
        end
        // Count mismatches before the held reading follows
        if (!cfg_i.direct_mode) begin
          stable_d = (held_q == avg_d) ? 6'd0 : stable_inc;
          if (stable_d >= cfg_i.stable_limit) begin
            stable_d = '0;
            held_d   = avg_d;
            valid_d  = 1'b1;
            upd_d    = 1'b1;
            lkp_d    = 1'b1;
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= '0;
      sum_q    <= '0;
      count_q  <= '0;
      max_q    <= '0;
      min_q    <= BlockMinRst;
      avg_q    <= '0;
      held_q   <= HeldReadingRst;
      stable_q <= '0;
      valid_q  <= 1'b0;
      upd_q    <= 1'b0;
      lkp_q    <= 1'b0;
    end else if (step_i) begin
      settle_q <= settle_d;
      sum_q    <= sum_d;
      count_q  <= count_d;
      max_q    <= max_d;
      min_q    <= min_d;
      avg_q    <= avg_d;
      held_q   <= held_d;
      stable_q <= stable_d;
      valid_q  <= valid_d;
      upd_q    <= upd_d;
      lkp_q    <= lkp_d;
    end
  end

  assign stat_o.updated      = upd_q;
  assign stat_o.need_lookup  = lkp_q;
  assign stat_o.held_reading = held_q;
  assign stat_o.valid        = valid_q;

`ifndef SYNTHESIS
  a_count_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < 4'(BlockLen))
    else $error("block count past block length");
  a_lookup_implies_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lkp_q |-> (upd_q && valid_q))
    else $error("lookup request without reading update");
  a_update_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_q |-> valid_q)
    else $error("update without valid flag");
`endif

endmodule

### sv/ntf_lookup.sv
// Table walk: one ROM compare per cycle to turn a reading into degrees Celsius.
module ntf_lookup #(
  parameter int unsigned TABLE_LEN = ntf_pkg::TableLen
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ntf_pkg::lkp_req_t req_i,
  output ntf_pkg::lkp_rsp_t rsp_o
);
  import ntf_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_LEN + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [7:0]      code_q, code_d;
  logic            advance;

  // Shared compare against the current ROM entry
  assign advance = busy_q && (idx_q < CntW'(TABLE_LEN)) && (code_q >= NtcRom[8'(idx_q)]);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    code_d = code_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      idx_d  = '0;
      code_d = req_i.code;
    end else if (advance) begin
      idx_d = idx_q + CntW'(1);
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  // Count of entries not above the code, less one when not zero
  assign rsp_o.done    = busy_q && !advance;
  assign rsp_o.celsius = (idx_q == '0) ? 8'd0 : 8'(idx_q - CntW'(1));

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("lookup started while walking");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= CntW'(TABLE_LEN)))
    else $error("walk index past table");
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> !busy_q)
    else $error("walk continues after done");
`endif

endmodule

### bench/ntc_reading_checker.sv
// Checker for the trimmed-mean ADC filter: mirrors the filter and compares every result transfer.
module ntc_reading_checker #(
  parameter int unsigned TABLE_LEN = ntf_pkg::TableLen
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  ntf_pkg::in_item_t            in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  ntf_pkg::out_item_t           out_data_i,
  input  logic                         cfg_we_i,
  input  logic [ntf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ntf_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int unsigned                  mismatch_count_o,
  output int unsigned                  pending_o,
  output int unsigned                  checked_o,
  output int unsigned                  replaced_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ntf_pkg::*;

  // Thermistor curve, ADC code per degree; the last five entries read as 255
  localparam logic [7:0] ThermCurve [256] = '{
    3,   4,   4,   4,   4,   5,   5,   5,   5,   6,
    6,   6,   7,   7,   7,   8,   8,   8,   9,   9,
    10,  10,  10,  11,  11,  12,  12,  13,  14,  14,
    15,  15,  16,  17,  17,  18,  19,  20,  20,  21,
    22,  23,  24,  24,  25,  26,  27,  28,  29,  30,
    31,  32,  34,  35,  36,  37,  38,  39,  41,  42,
    43,  45,  46,  47,  49,  50,  52,  53,  55,  56,
    58,  59,  61,  63,  64,  66,  68,  69,  71,  73,
    74,  76,  78,  80,  82,  83,  85,  87,  89,  91,
    93,  94,  96,  98,  100, 102, 104, 106, 108, 110,
    112, 113, 115, 117, 119, 121, 123, 125, 127, 129,
    130, 132, 134, 136, 138, 139, 141, 143, 145, 147,
    148, 150, 152, 153, 155, 157, 158, 160, 162, 163,
    165, 166, 168, 169, 171, 172, 174, 175, 177, 178,
    179, 181, 182, 183, 185, 186, 187, 188, 190, 191,
    192, 193, 194, 196, 197, 198, 199, 200, 201, 202,
    203, 204, 205, 206, 207, 208, 209, 209, 210, 211,
    212, 213, 214, 214, 215, 216, 217, 217, 218, 219,
    219, 220, 221, 221, 222, 223, 223, 224, 224, 225,
    226, 226, 227, 227, 228, 228, 229, 229, 230, 230,
    231, 231, 232, 232, 232, 233, 233, 234, 234, 234,
    235, 235, 236, 236, 236, 237, 237, 237, 238, 238,
    238, 239, 239, 239, 239, 240, 240, 240, 240, 241,
    241, 241, 241, 242, 242, 242, 242, 243, 243, 243,
    243, 243, 244, 244, 244, 244, 244, 245, 245, 245,
    245, 255, 255, 255, 255, 255
  };

  // Register copies
  logic       direct_q;
  logic       invert_q;
  logic [3:0] settle_q;
  logic [5:0] limit_q;

  // Filter state
  logic [3:0]  settle_cnt;
  logic [11:0] blk_sum;
  logic [3:0]  blk_cnt;
  logic [7:0]  blk_max;
  logic [7:0]  blk_min;
  logic [7:0]  blk_avg;
  logic [7:0]  held_code;
  logic [5:0]  stable_cnt;
  logic [7:0]  held_cel;
  logic        held_ok;

  out_item_t expected_readings [$];

  // Count the leading curve entries not above the code, then step back one
  function automatic logic [7:0] celsius_of(logic [7:0] code);
    int unsigned n;
    n = 0;
    while (n < TABLE_LEN && n < 256 && code >= ThermCurve[n]) n++;
    if (n != 0) n--;
    return n[7:0];
  endfunction

  // Advance the filter by one tick and return the result it shows
  function automatic out_item_t advance_filter(in_item_t tick);
    logic [11:0] trimmed;
    logic        replaced;
    out_item_t   res;
    replaced = 1'b0;
    if (tick.channel_busy) begin
      settle_cnt = '0;
      stable_cnt = '0;
    end else begin
      if (settle_cnt < settle_q) settle_cnt = settle_cnt + 4'd1;
      if (settle_cnt >= settle_q) begin
        blk_sum = blk_sum + 12'(tick.sample);
        blk_cnt = blk_cnt + 4'd1;
        if (tick.sample >= blk_max) blk_max = tick.sample;
        if (tick.sample <= blk_min) blk_min = tick.sample;
        // Close the block: drop min and max, average the other eight
        if (blk_cnt >= 4'(BlockLen)) begin
          trimmed = blk_sum - 12'(blk_min) - 12'(blk_max);
          blk_avg = trimmed[10:3];
          if (invert_q) blk_avg = ~blk_avg;
          blk_cnt = '0;
          blk_sum = '0;
          blk_max = '0;
          blk_min = 8'hff;
          if (direct_q) begin
            held_code = blk_avg;
            held_ok   = 1'b1;
            replaced  = 1'b1;
          end
        end
        // Replace the reading once enough mismatching ticks have passed
        if (!direct_q) begin
          stable_cnt = stable_cnt + 6'd1;
          if (held_code == blk_avg) stable_cnt = '0;
          if (stable_cnt >= limit_q) begin
            stable_cnt = '0;
            held_code  = blk_avg;
            held_cel   = celsius_of(held_code);
            held_ok    = 1'b1;
            replaced   = 1'b1;
          end
        end
      end
    end
    res.reading_updated = replaced;
    res.reading_code    = held_code;
    res.celsius         = held_cel;
    res.reading_valid   = held_ok;
    return res;
  endfunction

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count_o++;
    end
  endtask

  task automatic check_reading(out_item_t got);
    out_item_t want;
    if (expected_readings.size() == 0) begin
      $error("result transfer with nothing expected: %h", got);
      mismatch_count_o++;
      return;
    end
    want = expected_readings.pop_front();
    checked_o++;
    if (got.reading_updated === 1'b1) replaced_o++;
    compare_field("reading_updated", 8'(want.reading_updated), 8'(got.reading_updated));
    compare_field("reading_code", want.reading_code, got.reading_code);
    compare_field("celsius", want.celsius, got.celsius);
    compare_field("reading_valid", 8'(want.reading_valid), 8'(got.reading_valid));
  endtask

  // Track transfers and register writes at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direct_q   = 1'b0;
      invert_q   = 1'b0;
      settle_q   = 4'd10;
      limit_q    = 6'd50;
      settle_cnt = '0;
      blk_sum    = '0;
      blk_cnt    = '0;
      blk_max    = '0;
      blk_min    = 8'hff;
      blk_avg    = '0;
      held_code  = 8'd100;
      stable_cnt = '0;
      held_cel   = '0;
      held_ok    = 1'b0;
      expected_readings.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
      checked_o        = 0;
      replaced_o       = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_reading(out_data_i);
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          RegDirectMode:    direct_q = cfg_wdata_i[0];
          RegInvertAverage: invert_q = cfg_wdata_i[0];
          RegSettleTicks:   settle_q = cfg_wdata_i[3:0];
          RegStableLimit:   limit_q  = cfg_wdata_i[5:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_readings.push_back(advance_filter(in_data_i));
      pending_o = expected_readings.size();
    end
  end

endmodule

### bench/ntc_adc_trimmed_mean_filter_unit_tb.sv
// Testbench top for the trimmed-mean ADC filter: drives ticks and registers, gives the verdict.
module ntc_adc_trimmed_mean_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned PhaseTicks = 215;
  localparam int unsigned EndWait    = ntf_pkg::TableLen + 4;

  // Edge sweep for the first lookup block
  localparam logic [7:0] EdgeSweep [10] = '{255, 0, 170, 85, 1, 254, 128, 127, 200, 50};

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  ntf_pkg::in_item_t              in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  ntf_pkg::out_item_t             out_data_o;
  logic                           cfg_we_i    = 1'b0;
  logic [ntf_pkg::CfgIdxW-1:0]    cfg_idx_i   = '0;
  logic [ntf_pkg::CfgDataW-1:0]   cfg_wdata_i = '0;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned replaced;
  int unsigned cycle_count = 0;
  int unsigned ticks_sent  = 0;
  int unsigned settings    = 0;
  int unsigned failures;
  int          level       = 128;
  int unsigned busy_left   = 0;
  bit          steady      = 1'b0;

  ntc_adc_trimmed_mean_filter_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  ntc_reading_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .replaced_o       (replaced)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Stop a hung run
  initial begin
    wait (cycle_count >= CycleLimit);
    $error("run exceeded %0d cycles", CycleLimit);
    $display("FAIL");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Next random tick: a sensor level with jitter, outliers, noise and busy bursts
  function automatic ntf_pkg::in_item_t make_tick();
    ntf_pkg::in_item_t t;
    int                v;
    int unsigned       r;
    if ($urandom_range(99, 0) < 2) begin
      if ($urandom_range(3, 0) == 0) level = $urandom_range(1, 0) ? 255 : 0;
      else level = $urandom_range(255, 0);
    end
    if (busy_left == 0 && $urandom_range(99, 0) < 3) busy_left = $urandom_range(4, 1);
    t.sample       = 8'($urandom);
    t.channel_busy = 1'b0;
    if (busy_left != 0) begin
      busy_left--;
      t.channel_busy = 1'b1;
      return t;
    end
    r = $urandom_range(99, 0);
    if (r < 75) begin
      v = level + int'($urandom_range(6, 0)) - 3;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      t.sample = 8'(v);
    end else if (r >= 88) begin
      t.sample = $urandom_range(1, 0) ? 8'hff : 8'h00;
    end
    return t;
  endfunction

  // Present one tick and hold it until the transfer
  task automatic send_tick(logic busy, logic [7:0] s);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    in_data_i.sample       <= s;
    in_data_i.channel_busy <= busy;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ticks_sent++;
  endtask

  // Drop valid and wait until every result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Write all four registers on consecutive edges
  task automatic apply_config(logic direct, logic inv, logic [3:0] settle, logic [5:0] limit);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= ntf_pkg::RegDirectMode;
    cfg_wdata_i <= ntf_pkg::CfgDataW'(direct);
    @(posedge clk_i);
    cfg_idx_i   <= ntf_pkg::RegInvertAverage;
    cfg_wdata_i <= ntf_pkg::CfgDataW'(inv);
    @(posedge clk_i);
    cfg_idx_i   <= ntf_pkg::RegSettleTicks;
    cfg_wdata_i <= ntf_pkg::CfgDataW'(settle);
    @(posedge clk_i);
    cfg_idx_i   <= ntf_pkg::RegStableLimit;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings++;
  endtask

  task automatic run_phase(logic direct, logic inv, logic [3:0] settle, logic [5:0] limit,
                           bit quiet);
    ntf_pkg::in_item_t t;
    steady = quiet;
    apply_config(direct, inv, settle, limit);
    repeat (PhaseTicks) begin
      t = make_tick();
      send_tick(t.channel_busy, t.sample);
    end
    drain();
  endtask

  // Result side: ready for a while, then stall
  initial begin
    int unsigned hold;
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      hold = $urandom_range(8, 1);
      repeat (hold) @(posedge clk_i);
      hold = draw_gap();
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: still settling, held reading shows its reset value
    send_tick(1'b1, 8'h00);
    send_tick(1'b0, 8'h00);
    send_tick(1'b0, 8'hff);
    drain();

    // Lookup mode, shortest limits: replace before any block, then an edge sweep
    apply_config(1'b0, 1'b0, 4'd1, 6'd1);
    foreach (EdgeSweep[i]) send_tick(1'b0, EdgeSweep[i]);
    send_tick(1'b1, 8'ha5);
    send_tick(1'b0, 8'hfa);
    drain();

    // Direct mode with inversion; celsius must hold its last value
    apply_config(1'b1, 1'b1, 4'd1, 6'd63);
    repeat (10) send_tick(1'b0, 8'hff);
    drain();

    // Random phases: register extremes first, then random settings
    run_phase(1'b0, 1'b0, 4'd1, 6'd1, 1'b0);
    run_phase(1'b1, 1'b0, 4'd15, 6'd63, 1'b1);
    run_phase(1'b0, 1'b1, 4'd15, 6'd63, 1'b0);
    run_phase(1'b1, 1'b1, 4'd1, 6'd1, 1'b0);
    for (int k = 0; k < 4; k++) begin
      run_phase(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                4'($urandom_range(15, 1)),
                ($urandom_range(3, 0) == 0) ? 6'($urandom_range(63, 1))
                                            : 6'($urandom_range(8, 1)),
                k == 2);
    end

    // Catch any stray result before the verdict
    repeat (EndWait) @(posedge clk_i);
    @(negedge clk_i);
    failures = mismatch_count;
    if (pending != 0) begin
      $error("%0d expected results never arrived", pending);
      failures += pending;
    end
    $display("Covered %0d ticks under %0d register settings, direct and lookup modes.",
             ticks_sent, settings);
    $display("Compared %0d results, %0d of them reading replacements.", checked, replaced);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
